// ===== design/sads_pkg.sv =====
// Package for the shared-array double stack: request and status codes,
// field widths, and the command/status structs between controller and datapath.
// No dependencies.
package sads_pkg;

   localparam int VALUE_BITS  = 32;
   localparam int STATUS_BITS = 2;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   localparam logic SIDE_LEFT  = 1'b0;
   localparam logic SIDE_RIGHT = 1'b1;

   localparam logic [STATUS_BITS-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd2;

   // controller to datapath
   typedef struct packed {
      logic                   push;      // write one cell, bump the pointer
      logic                   pop;       // read one cell, drop the pointer
      logic                   side;
      logic                   rsp_load;  // load result from request value or zero
      logic                   rsp_zero;
      logic                   rsp_mem;   // load result from memory read data
      logic [STATUS_BITS-1:0] status;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic full;
      logic left_empty;
      logic right_empty;
   } stat_type;

endpackage

// ===== design/sads_datapath.sv =====
// Datapath for the shared-array double stack: cell memory, the two stack
// counters and the result register. Depends on sads_pkg.
module sads_datapath
   import sads_pkg::*;
#(
   parameter int DEPTH     = 32,
   parameter int WORD_BITS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   input  logic [VALUE_BITS-1:0]  value,
   output stat_type               stat,
   output logic [VALUE_BITS-1:0]  result_value,
   output logic [STATUS_BITS-1:0] status
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int AW = $clog2(DEPTH);
   // only the low bits of the 32-bit request word can ever be stored
   localparam int STORE_BITS = (WORD_BITS < VALUE_BITS) ? WORD_BITS : VALUE_BITS;
   localparam logic [CW-1:0] DEPTH_C   = CW'(DEPTH);
   localparam logic [CW:0]   DEPTH_SUM = (CW + 1)'(DEPTH);

   logic [STORE_BITS-1:0] mem [DEPTH];

   logic [CW-1:0]          left_ff, left_in;
   logic [CW-1:0]          right_ff, right_in;
   logic [STORE_BITS-1:0]  rd_ff;
   logic [VALUE_BITS-1:0]  data_ff, data_in;
   logic [STATUS_BITS-1:0] status_ff, status_in;

   logic [CW:0]           used;
   logic [CW-1:0]         addr_wide;
   logic [AW-1:0]         addr;
   logic [VALUE_BITS-1:0] value_ext;
   logic [VALUE_BITS-1:0] rd_ext;

   assign used = {1'b0, left_ff} + {1'b0, right_ff};

   assign stat.full        = (used >= DEPTH_SUM);
   assign stat.left_empty  = (left_ff == '0);
   assign stat.right_empty = (right_ff == '0);

   // left grows up from cell 0, right grows down from the last cell
   always_comb begin
      case (cmd.side)
         SIDE_LEFT: begin
            addr_wide = cmd.push ? left_ff : left_ff - CW'(1);
         end
         SIDE_RIGHT: begin
            addr_wide = cmd.push ? DEPTH_C - CW'(1) - right_ff : DEPTH_C - right_ff;
         end
         default: begin
            addr_wide = left_ff;
         end
      endcase
   end

   assign addr = addr_wide[AW-1:0];

   always_comb begin
      left_in  = left_ff;
      right_in = right_ff;
      if (cmd.push) begin
         if (cmd.side == SIDE_LEFT) left_in = left_ff + CW'(1);
         else right_in = right_ff + CW'(1);
      end else if (cmd.pop) begin
         if (cmd.side == SIDE_LEFT) left_in = left_ff - CW'(1);
         else right_in = right_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff  <= '0;
         right_ff <= '0;
      end else begin
         left_ff  <= left_in;
         right_ff <= right_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         mem[addr] <= value[STORE_BITS-1:0];
      end
      if (cmd.pop) begin
         rd_ff <= mem[addr];
      end
   end

   always_comb begin
      value_ext = '0;
      value_ext[STORE_BITS-1:0] = value[STORE_BITS-1:0];
      rd_ext = '0;
      rd_ext[STORE_BITS-1:0] = rd_ff;
   end

   always_comb begin
      data_in   = data_ff;
      status_in = status_ff;
      if (cmd.rsp_load) begin
         data_in   = cmd.rsp_zero ? '0 : value_ext;
         status_in = cmd.status;
      end else if (cmd.rsp_mem) begin
         data_in   = rd_ext;
         status_in = cmd.status;
      end
   end

   always_ff @(posedge clock) begin
      data_ff   <= data_in;
      status_ff <= status_in;
   end

   assign result_value = data_ff;
   assign status       = status_ff;

`ifndef SYNTHESIS
   a_never_overfill: assert property (@(posedge clock) disable iff (reset)
      used <= DEPTH_SUM)
      else $error("stacks hold more words than the array");

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> !stat.full)
      else $error("push issued into a full array");

   a_pop_has_word: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> ((cmd.side == SIDE_LEFT) ? !stat.left_empty : !stat.right_empty))
      else $error("pop issued on an empty side");

   a_pop_drops_left: assert property (@(posedge clock) disable iff (reset)
      (cmd.pop && cmd.side == SIDE_LEFT) |=> left_ff == $past(left_ff) - CW'(1))
      else $error("left pointer did not drop after pop");
`endif

endmodule

// ===== design/sads_ctrl.sv =====
// Controller for the shared-array double stack: decodes each request against
// the stack status and sequences memory access and result handoff. Depends on sads_pkg.
module sads_ctrl
   import sads_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  logic     req_op,
   input  logic     req_side,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_READ = 2'd1;
   localparam logic [1:0] S_RESP = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       side_empty;

   assign side_empty = (req_side == SIDE_LEFT) ? stat.left_empty : stat.right_empty;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.side     = req_side;
      cmd.status   = STATUS_OK;
      req_ready    = 1'b0;
      rsp_valid    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_op == OP_PUSH) begin
                  cmd.rsp_load = 1'b1;
                  if (stat.full) begin
                     cmd.rsp_zero = 1'b1;
                     cmd.status   = STATUS_FULL;
                  end else begin
                     cmd.push = 1'b1;
                  end
                  state_in = S_RESP;
               end else if (side_empty) begin
                  cmd.rsp_load = 1'b1;
                  cmd.rsp_zero = 1'b1;
                  cmd.status   = STATUS_EMPTY;
                  state_in     = S_RESP;
               end else begin
                  cmd.pop  = 1'b1;
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            // read data is registered; capture it into the result
            cmd.rsp_mem = 1'b1;
            state_in    = S_RESP;
         end
         S_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

`ifndef SYNTHESIS
   a_read_after_pop: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |-> $past(cmd.pop))
      else $error("read state entered without a pop");

   a_one_action: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.push, cmd.pop, cmd.rsp_mem}))
      else $error("more than one datapath action in a cycle");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request accepted while a result is pending");
`endif

endmodule

// ===== design/shared_array_double_stack_top.sv =====
// Top level of the shared-array double stack: stream ports, controller and
// datapath. Depends on sads_pkg, sads_ctrl and sads_datapath.
//
//   channel  direction  tdata                     tuser
//   req      in         [31:0] value              [0] op, [1] side
//   rsp      out        [31:0] result_value       [1:0] status
//
// One item at a time. A push, or a refused push or pop, shows its result in the
// cycle after acceptance; a pop passes through an extra state, the registered
// read of the cell memory, before its result shows. The next item is taken the
// cycle after the result is taken. Reset clears both stack pointers; cells are
// not cleared. A stalled result holds its data and blocks new items.
module shared_array_double_stack_top
   import sads_pkg::*;
#(
   parameter int DEPTH     = 32,
   parameter int WORD_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // value
   input  logic [1:0]  req_tuser,   // op, side
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // result_value
   output logic [1:0]  rsp_tuser    // status
);

   cmd_type  cmd;
   stat_type stat;

   sads_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_op    (req_tuser[0]),
      .req_side  (req_tuser[1]),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .stat      (stat),
      .cmd       (cmd)
   );

   sads_datapath #(
      .DEPTH     (DEPTH),
      .WORD_BITS (WORD_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .value        (req_tdata),
      .stat         (stat),
      .result_value (rsp_tdata),
      .status       (rsp_tuser)
   );

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Testbench for shared_array_double_stack_top: push/pop items on both stacks,
// predicted in-line and checked against each result. Depends on sads_pkg.
module tb;
   import sads_pkg::*;

   localparam int DEPTH     = 32;
   localparam int N_RANDOM  = 1300;
   localparam int MAX_SHOWN = 10;

   typedef struct {
      logic        op;
      logic        side;
      logic [31:0] value;
   } stack_req_type;

   typedef struct {
      logic [31:0]            value;
      logic [STATUS_BITS-1:0] status;
   } stack_rsp_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;   // value
   logic [1:0]  req_tuser  = '0;   // op, side
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // result_value
   logic [1:0]  rsp_tuser;         // status

   stack_req_type  req_backlog[$];
   stack_rsp_type  expected_rsp[$];

   // stack model
   logic [31:0] stack_cells[DEPTH];
   int          left_depth  = 0;
   int          right_depth = 0;

   int          n_errors = 0;
   int          cycle_cnt = 0;
   logic        steady;

   shared_array_double_stack_top #(
      .DEPTH     (DEPTH),
      .WORD_BITS (32)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // no idling on either side in this window
   assign steady = (cycle_cnt >= 1500) && (cycle_cnt < 3000);

   task automatic predict_stack_op(input logic op, input logic side, input logic [31:0] word);
      stack_rsp_type r;
      int            idx;
      r.value  = '0;
      r.status = STATUS_OK;
      if (op == OP_PUSH) begin
         if (left_depth + right_depth >= DEPTH) begin
            r.status = STATUS_FULL;
         end else begin
            if (side == SIDE_LEFT) begin
               idx = left_depth;
               left_depth++;
            end else begin
               right_depth++;
               idx = DEPTH - right_depth;
            end
            stack_cells[idx] = word;
            r.value = word;
         end
      end else if (side == SIDE_LEFT) begin
         if (left_depth == 0) begin
            r.status = STATUS_EMPTY;
         end else begin
            left_depth--;
            r.value = stack_cells[left_depth];
         end
      end else begin
         if (right_depth == 0) begin
            r.status = STATUS_EMPTY;
         end else begin
            r.value = stack_cells[DEPTH - right_depth];
            right_depth--;
         end
      end
      expected_rsp.push_back(r);
   endtask

   function automatic logic [31:0] pick_word();
      case ($urandom_range(9))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic stack_req_type mk_req(input logic op, input logic side,
                                            input logic [31:0] word);
      stack_req_type q;
      q.op    = op;
      q.side  = side;
      q.value = word;
      return q;
   endfunction

   // driver: present items from the backlog, idle now and then
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         cycle_cnt <= cycle_cnt + 1;
         if (req_tvalid && req_tready)
            predict_stack_op(req_tuser[0], req_tuser[1], req_tdata);
         if (!req_tvalid || req_tready) begin
            if (req_backlog.size() > 0 && (steady || $urandom_range(99) >= 16)) begin
               req_tvalid <= 1'b1;
               req_tuser  <= {req_backlog[0].side, req_backlog[0].op};
               req_tdata  <= req_backlog[0].value;
               void'(req_backlog.pop_front());
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor: stall the result side at random, compare each taken item
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_rsp.size() == 0) begin
               n_errors++;
               if (n_errors <= MAX_SHOWN)
                  $display("unexpected result: value %h status %0d", rsp_tdata, rsp_tuser);
            end else begin
               if (rsp_tdata !== expected_rsp[0].value ||
                   rsp_tuser !== expected_rsp[0].status) begin
                  n_errors++;
                  if (n_errors <= MAX_SHOWN)
                     $display("mismatch: expected value %h status %0d, got value %h status %0d",
                              expected_rsp[0].value, expected_rsp[0].status,
                              rsp_tdata, rsp_tuser);
               end
               void'(expected_rsp.pop_front());
            end
         end
         rsp_tready <= steady || ($urandom_range(99) >= 16);
      end
   end

   initial begin
      int n;
      int seg_len;
      int push_pct;
      int side_mode;
      logic op;
      logic side;

      // pops on empty sides, extreme words, LIFO order on both sides
      req_backlog.push_back(mk_req(OP_POP,  SIDE_LEFT,  32'h0));
      req_backlog.push_back(mk_req(OP_POP,  SIDE_RIGHT, 32'hFFFF_FFFF));
      req_backlog.push_back(mk_req(OP_PUSH, SIDE_LEFT,  32'h7FFF_FFFF));
      req_backlog.push_back(mk_req(OP_PUSH, SIDE_RIGHT, 32'h8000_0000));
      req_backlog.push_back(mk_req(OP_PUSH, SIDE_LEFT,  32'h0000_0000));
      req_backlog.push_back(mk_req(OP_PUSH, SIDE_RIGHT, 32'hFFFF_FFFF));
      req_backlog.push_back(mk_req(OP_PUSH, SIDE_LEFT,  32'h0000_0001));
      req_backlog.push_back(mk_req(OP_POP,  SIDE_LEFT,  32'h0));
      req_backlog.push_back(mk_req(OP_POP,  SIDE_RIGHT, 32'h0));
      req_backlog.push_back(mk_req(OP_POP,  SIDE_LEFT,  32'h0));
      req_backlog.push_back(mk_req(OP_POP,  SIDE_RIGHT, 32'h0));
      req_backlog.push_back(mk_req(OP_POP,  SIDE_LEFT,  32'h0));
      req_backlog.push_back(mk_req(OP_POP,  SIDE_LEFT,  32'h0));
      req_backlog.push_back(mk_req(OP_POP,  SIDE_RIGHT, 32'h0));

      // random segments: fill-heavy, drain-heavy or balanced, with side bias
      n = 0;
      while (n < N_RANDOM) begin
         seg_len   = $urandom_range(60, 10);
         case ($urandom_range(2))
            0:       push_pct = 85;
            1:       push_pct = 15;
            default: push_pct = 50;
         endcase
         side_mode = $urandom_range(3);
         for (int i = 0; i < seg_len && n < N_RANDOM; i++) begin
            op = ($urandom_range(99) < push_pct) ? OP_PUSH : OP_POP;
            case (side_mode)
               0:       side = SIDE_LEFT;
               1:       side = SIDE_RIGHT;
               default: side = 1'($urandom_range(1));
            endcase
            req_backlog.push_back(mk_req(op, side, (op == OP_PUSH) ? pick_word() : $urandom));
            n++;
         end
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      wait (req_backlog.size() == 0 && !req_tvalid && expected_rsp.size() == 0);
      repeat (10) @(posedge clock);
      if (n_errors == 0 && expected_rsp.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule

// ===== shared_array_double_stack_top.f =====
design/sads_pkg.sv
design/sads_datapath.sv
design/sads_ctrl.sv
design/shared_array_double_stack_top.sv
tb/sv/tb.sv
